>>> rtl/sws_pkg.sv
// Shared types and character codes for the shell word splitter.
`default_nettype none

package sws_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_OK   = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_SINGLE = 2'd1,
		QUOTE_DOUBLE = 2'd2
	} quote_t;

	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [5:0]  arg_number;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0]  count;
		res_t        r0;
		res_t        r1;
	} step_out_t;

endpackage

`default_nettype wire

>>> rtl/sws_step.sv
// Per-byte split logic: next parser state and up to two results.
`default_nettype none

module sws_step import sws_pkg::*; #(
	parameter int ARG_LIMIT = 64,
	parameter int ARG_BYTES = 1024
) (
	input  quote_t                         quote,
	input  logic                           escape,
	input  logic [$clog2(ARG_BYTES)-1:0]   length,
	input  logic [$clog2(ARG_LIMIT)-1:0]   count,
	input  logic [7:0]                     text_byte,
	input  logic                           end_of_line,
	output quote_t                         quote_nxt,
	output logic                           escape_nxt,
	output logic [$clog2(ARG_BYTES)-1:0]   length_nxt,
	output logic [$clog2(ARG_LIMIT)-1:0]   count_nxt,
	output step_out_t                      res
);

	localparam int LEN_W = $clog2(ARG_BYTES);
	localparam int CNT_W = $clog2(ARG_LIMIT);
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(ARG_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(ARG_LIMIT - 1);

	logic             eol;
	logic             blank;
	logic             special;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W+5:0] cur_ext;
	logic [CNT_W+5:0] inc_ext;
	logic [5:0]       num_cur;
	logic [5:0]       num_inc;
	logic             do_keep;
	logic             add_bsl;
	logic             k1;
	logic             k2;
	logic [LEN_W-1:0] len_a;
	res_t             bsl_res;
	res_t             chr_res;

	assign eol       = end_of_line || (text_byte == CH_NUL);
	assign blank     = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
	assign special   = (text_byte == CH_BSL) || (text_byte == CH_DQ) ||
		(text_byte == CH_DOLLAR) || (text_byte == CH_NL);
	assign count_inc = count + CNT_W'(1);
	// arg_number is the count taken modulo 64
	assign cur_ext   = {6'd0, count};
	assign inc_ext   = {6'd0, count_inc};
	assign num_cur   = cur_ext[5:0];
	assign num_inc   = inc_ext[5:0];

	// backslash first (if kept), then the byte; each against the length cap
	assign k1    = add_bsl && (length < LEN_CAP);
	assign len_a = length + LEN_W'(k1);
	assign k2    = len_a < LEN_CAP;

	always_comb begin
		bsl_res            = '0;
		bsl_res.kind       = KIND_BYTE;
		bsl_res.data       = CH_BSL;
		bsl_res.arg_number = num_cur;
		chr_res            = '0;
		chr_res.kind       = KIND_BYTE;
		chr_res.data       = text_byte;
		chr_res.arg_number = num_cur;
	end

	always_comb begin
		quote_nxt  = quote;
		escape_nxt = escape;
		length_nxt = length;
		count_nxt  = count;
		do_keep    = 1'b0;
		add_bsl    = 1'b0;
		res        = '0;
		if (eol) begin
			quote_nxt  = QUOTE_NONE;
			escape_nxt = 1'b0;
			length_nxt = '0;
			count_nxt  = '0;
			if (quote != QUOTE_NONE) begin
				res.count         = 2'd1;
				res.r0.kind       = KIND_ERR;
				res.r0.arg_number = num_cur;
			end else if (length != '0) begin
				res.count         = 2'd2;
				res.r0.kind       = KIND_END;
				res.r0.arg_number = num_cur;
				res.r1.kind       = KIND_OK;
				res.r1.arg_number = num_inc;
			end else begin
				res.count         = 2'd1;
				res.r0.kind       = KIND_OK;
				res.r0.arg_number = num_cur;
			end
		end else if (count >= CNT_CAP) begin
			// argument cap hit: drop the rest of the line
		end else if (escape) begin
			escape_nxt = 1'b0;
			do_keep    = 1'b1;
			add_bsl    = (quote == QUOTE_DOUBLE) && !special;
		end else if (text_byte == CH_BSL && quote != QUOTE_SINGLE) begin
			escape_nxt = 1'b1;
		end else if (text_byte == CH_SQ && quote != QUOTE_DOUBLE) begin
			quote_nxt = (quote == QUOTE_SINGLE) ? QUOTE_NONE : QUOTE_SINGLE;
		end else if (text_byte == CH_DQ && quote != QUOTE_SINGLE) begin
			quote_nxt = (quote == QUOTE_DOUBLE) ? QUOTE_NONE : QUOTE_DOUBLE;
		end else if (blank && quote == QUOTE_NONE) begin
			if (length != '0) begin
				res.count         = 2'd1;
				res.r0.kind       = KIND_END;
				res.r0.arg_number = num_cur;
				count_nxt         = count_inc;
				length_nxt        = '0;
			end
		end else begin
			do_keep = 1'b1;
		end

		if (do_keep) begin
			res.count  = 2'({1'b0, k1} + {1'b0, k2});
			res.r0     = k1 ? bsl_res : chr_res;
			res.r1     = chr_res;
			length_nxt = len_a + LEN_W'(k2);
		end

		res.r0.last = (res.count == 2'd1);
		res.r1.last = 1'b1;
	end

endmodule

`default_nettype wire

>>> rtl/shell_word_splitter.sv
// Top level: parser state registers and a two-slot result buffer.
//
//  channel | signals                                      | role
//  --------+----------------------------------------------+-------------------
//  in      | in_valid, in_ready, text_byte, end_of_line   | one line byte/beat
//  out     | out_valid, out_ready, kind, out_byte,        | one result/beat
//          | arg_number, last_of_run                      |
//
// One input beat per cycle while in_ready is high; a beat that yields two results
// holds in_ready low while the second result drains. Results appear the cycle after
// the input beat. in_ready rises whenever the two-slot buffer will be empty
// after this cycle's output beat. Reset clears parser state and the buffer.
`default_nettype none

module shell_word_splitter import sws_pkg::*; #(
	parameter int ARG_LIMIT = 64,
	parameter int ARG_BYTES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [5:0] arg_number,
	output logic       last_of_run
);

	localparam int LEN_W = $clog2(ARG_BYTES);
	localparam int CNT_W = $clog2(ARG_LIMIT);

	quote_t           quote_q, quote_nxt;
	logic             escape_q, escape_nxt;
	logic [LEN_W-1:0] length_q, length_nxt;
	logic [CNT_W-1:0] count_q, count_nxt;
	step_out_t        step;
	res_t             slot0_q, slot1_q;
	logic [1:0]       fill_q;
	logic             push, pop;

	sws_step #(
		.ARG_LIMIT (ARG_LIMIT),
		.ARG_BYTES (ARG_BYTES)
	) u_step (
		.quote       (quote_q),
		.escape      (escape_q),
		.length      (length_q),
		.count       (count_q),
		.text_byte   (text_byte),
		.end_of_line (end_of_line),
		.quote_nxt   (quote_nxt),
		.escape_nxt  (escape_nxt),
		.length_nxt  (length_nxt),
		.count_nxt   (count_nxt),
		.res         (step)
	);

	assign out_valid = (fill_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign in_ready  = (fill_q == 2'd0) || (fill_q == 2'd1 && pop);
	assign push      = in_valid && in_ready;

	assign kind        = slot0_q.kind;
	assign out_byte    = slot0_q.data;
	assign arg_number  = slot0_q.arg_number;
	assign last_of_run = slot0_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q  <= QUOTE_NONE;
			escape_q <= 1'b0;
			length_q <= '0;
			count_q  <= '0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				quote_q  <= quote_nxt;
				escape_q <= escape_nxt;
				length_q <= length_nxt;
				count_q  <= count_nxt;
				fill_q   <= step.count;
			end else if (pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// push only happens with the buffer draining empty, so it reloads both slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= step.r0;
			slot1_q <= step.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("result buffer fill out of range");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && (end_of_line || text_byte == CH_NUL) |=>
		quote_q == QUOTE_NONE && !escape_q && length_q == '0 && count_q == '0)
		else $error("parser state not cleared after line end");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_OK || kind == KIND_ERR) |-> last_of_run)
		else $error("line status is not the last result of its beat");

	a_second_slot_last: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 2'd2 |-> slot1_q.last && !slot0_q.last)
		else $error("two-result beat with bad last flags");

endmodule

`default_nettype wire
